/* rtl/sdfc_pkg.sv */
// ----------------------------------------------------------------------------
// SDF channel package
// Shared widths, register indexes, status codes, handshake structs and the
// small helper functions of the synchronous-dataflow channel buffer.
// ----------------------------------------------------------------------------
package sdfc_pkg;

   localparam int MAX_DEPTH = 256;
   localparam int TOKEN_W   = 32;
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
   localparam int PTR_W     = $clog2(MAX_DEPTH);
   localparam int RATE_W    = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 9;
   localparam int STATUS_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRODUCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSUME = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RING    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_TOKENS = 2'd2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic div_commit;
      logic exec;
      logic resp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic norm_needed;
      logic div_done;
   } dp_status_type;

   function automatic logic [DEPTH_W-1:0] eff_depth(input logic [CSR_DATA_W-1:0] raw);
      logic [DEPTH_W-1:0] res;
      if (raw == '0) begin
         res = DEPTH_W'(1);
      end else if (raw > CSR_DATA_W'(MAX_DEPTH)) begin
         res = DEPTH_W'(MAX_DEPTH);
      end else begin
         res = DEPTH_W'(raw);
      end
      return res;
   endfunction

   function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] raw);
      return (raw == '0) ? RATE_W'(1) : raw;
   endfunction

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] pos,
                                                input logic [DEPTH_W-1:0] depth);
      logic [DEPTH_W-1:0] nxt;
      nxt = DEPTH_W'(pos) + DEPTH_W'(1);
      return (nxt == depth) ? '0 : nxt[PTR_W-1:0];
   endfunction

endpackage

/* rtl/sdfc_remdiv.sv */
// ----------------------------------------------------------------------------
// SDF channel remainder unit
// Restoring division that reduces a slot pointer modulo the channel depth,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdfc_remdiv
   import sdfc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PTR_W-1:0]   dividend,
   input  logic [DEPTH_W-1:0] divisor,
   output logic               done,
   output logic [PTR_W-1:0]   remainder
);

   localparam int STEP_W = $clog2(PTR_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PTR_W-1:0]  rem_ff, rem_in;
   logic [PTR_W-1:0]  dvd_ff, dvd_in;
   logic [DEPTH_W-1:0] trial;
   logic [DEPTH_W-1:0] diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[PTR_W-1]};
      diff    = trial - divisor;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = (trial >= divisor) ? diff[PTR_W-1:0] : trial[PTR_W-1:0];
         dvd_in  = {dvd_ff[PTR_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(PTR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/sdfc_datapath.sv */
// ----------------------------------------------------------------------------
// SDF channel datapath
// Configuration registers, channel counters and pointers, token store with
// per-slot valid bits, pointer normalization and the result register.
// ----------------------------------------------------------------------------
module sdfc_datapath
   import sdfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         sts,
   input  logic                  req_kind,
   input  logic [TOKEN_W-1:0]    req_token_in,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [TOKEN_W-1:0]    rsp_token_out,
   output logic                  rsp_burst_last,
   output logic [DEPTH_W-1:0]    rsp_occupancy
);

   localparam logic [1:0] NORM_HEAD = 2'd0;
   localparam logic [1:0] NORM_WPOS = 2'd1;
   localparam logic [1:0] NORM_RPOS = 2'd2;

   logic [CSR_DATA_W-1:0] cfg_depth_ff, cfg_depth_in;
   logic [RATE_W-1:0]     cfg_prate_ff, cfg_prate_in;
   logic [RATE_W-1:0]     cfg_crate_ff, cfg_crate_in;
   logic [CSR_DATA_W-1:0] cfg_delay_ff, cfg_delay_in;
   logic                  cfg_ring_ff, cfg_ring_in;

   logic [DEPTH_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   wpos_ff, wpos_in;
   logic [RATE_W-1:0]  wbi_ff, wbi_in;
   logic [PTR_W-1:0]   rpos_ff, rpos_in;
   logic [RATE_W-1:0]  rbi_ff, rbi_in;

   logic               kind_ff, kind_in;
   logic [TOKEN_W-1:0] tok_ff, tok_in;
   logic [1:0]         norm_sel_ff, norm_sel_in;

   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic                pend_last_ff, pend_last_in;
   logic [DEPTH_W-1:0]  pend_occ_ff, pend_occ_in;
   logic                pend_rd_ff, pend_rd_in;

   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TOKEN_W-1:0]  rsp_token_ff, rsp_token_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [DEPTH_W-1:0]  rsp_occ_ff, rsp_occ_in;

   logic [TOKEN_W-1:0]  token_mem [MAX_DEPTH];
   logic [MAX_DEPTH-1:0] valid_ff;
   logic [TOKEN_W-1:0]  rd_data_ff;
   logic                rd_valid_ff;
   logic                mem_we;
   logic                mem_re;

   logic [DEPTH_W-1:0] depth;
   logic [DEPTH_W-1:0] count_c;
   logic [RATE_W-1:0]  prate;
   logic [RATE_W-1:0]  crate;
   logic               head_big, wpos_big, rpos_big;
   logic [1:0]         norm_pick;
   logic [PTR_W-1:0]   div_dividend;
   logic               div_done;
   logic [PTR_W-1:0]   div_rem;

   logic [DEPTH_W-1:0] space;
   logic [DEPTH_W-1:0] sum_hc;
   logic [DEPTH_W-1:0] sum_hc_wrap;
   logic [PTR_W-1:0]   w_start;
   logic               w_go;
   logic [RATE_W-1:0]  wbi_next;
   logic               w_last;
   logic [DEPTH_W:0]   sum_cr;
   logic [DEPTH_W-1:0] w_count;
   logic [PTR_W-1:0]   r_start;
   logic               r_go;
   logic [RATE_W-1:0]  rbi_next;
   logic               r_last;
   logic [DEPTH_W-1:0] r_count;
   logic [PTR_W-1:0]   r_adv;

   logic [DEPTH_W-1:0] new_depth;
   logic [CSR_DATA_W-1:0] new_delay;
   logic [DEPTH_W-1:0] reload_count;

   always_comb begin
      depth   = eff_depth(cfg_depth_ff);
      count_c = (count_ff > depth) ? depth : count_ff;
      prate   = eff_rate(cfg_prate_ff);
      crate   = eff_rate(cfg_crate_ff);

      head_big = DEPTH_W'(head_ff) >= depth;
      wpos_big = DEPTH_W'(wpos_ff) >= depth;
      rpos_big = DEPTH_W'(rpos_ff) >= depth;
      if (head_big) begin
         norm_pick    = NORM_HEAD;
         div_dividend = head_ff;
      end else if (wpos_big) begin
         norm_pick    = NORM_WPOS;
         div_dividend = wpos_ff;
      end else begin
         norm_pick    = NORM_RPOS;
         div_dividend = rpos_ff;
      end

      space       = depth - count_c;
      sum_hc      = DEPTH_W'(head_ff) + count_c;
      sum_hc_wrap = (sum_hc >= depth) ? sum_hc - depth : sum_hc;
      if (wbi_ff != '0) begin
         w_start = wpos_ff;
         w_go    = 1'b1;
      end else if (cfg_ring_ff) begin
         w_start = sum_hc_wrap[PTR_W-1:0];
         w_go    = space >= prate;
      end else begin
         w_start = '0;
         w_go    = count_c == '0;
      end
      wbi_next = wbi_ff + RATE_W'(1);
      w_last   = (wbi_next >= prate) || (wbi_next == '0);
      sum_cr   = {1'b0, count_c} + {1'b0, prate};
      w_count  = (sum_cr > {1'b0, depth}) ? depth : sum_cr[DEPTH_W-1:0];

      if (rbi_ff != '0) begin
         r_start = rpos_ff;
         r_go    = 1'b1;
      end else if (cfg_ring_ff) begin
         r_start = head_ff;
         r_go    = count_c >= crate;
      end else begin
         r_start = '0;
         r_go    = count_c != '0;
      end
      rbi_next = rbi_ff + RATE_W'(1);
      r_last   = (rbi_next >= crate) || (rbi_next == '0);
      r_count  = (count_c > crate) ? count_c - crate : '0;
      r_adv    = advance(r_start, depth);

      new_depth    = eff_depth((csr_index == CSR_DEPTH) ? csr_wdata : cfg_depth_ff);
      new_delay    = (csr_index == CSR_DELAY) ? csr_wdata : cfg_delay_ff;
      reload_count = (DEPTH_W'(new_delay) < new_depth) ? DEPTH_W'(new_delay) : new_depth;
   end

   always_comb begin
      cfg_depth_in   = cfg_depth_ff;
      cfg_prate_in   = cfg_prate_ff;
      cfg_crate_in   = cfg_crate_ff;
      cfg_delay_in   = cfg_delay_ff;
      cfg_ring_in    = cfg_ring_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      wpos_in        = wpos_ff;
      wbi_in         = wbi_ff;
      rpos_in        = rpos_ff;
      rbi_in         = rbi_ff;
      kind_in        = kind_ff;
      tok_in         = tok_ff;
      norm_sel_in    = norm_sel_ff;
      pend_status_in = pend_status_ff;
      pend_last_in   = pend_last_ff;
      pend_occ_in    = pend_occ_ff;
      pend_rd_in     = pend_rd_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_token_in   = rsp_token_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_occ_in     = rsp_occ_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;

      if (cmd.accept) begin
         kind_in = req_kind;
         tok_in  = req_token_in;
      end

      if (cmd.div_start) begin
         norm_sel_in = norm_pick;
      end

      if (cmd.div_commit) begin
         unique case (norm_sel_ff)
            NORM_HEAD: head_in = div_rem;
            NORM_WPOS: wpos_in = div_rem;
            default:   rpos_in = div_rem;
         endcase
      end

      if (cmd.exec) begin
         count_in     = count_c;
         pend_last_in = 1'b0;
         if (kind_ff == KIND_WRITE) begin
            pend_rd_in = 1'b0;
            if (wbi_ff == '0) begin
               wpos_in = w_start;
            end
            if (!w_go) begin
               pend_status_in = STATUS_NO_SPACE;
            end else begin
               pend_status_in = STATUS_OK;
               mem_we         = 1'b1;
               wpos_in        = advance(w_start, depth);
               if (w_last) begin
                  wbi_in       = '0;
                  pend_last_in = 1'b1;
                  count_in     = cfg_ring_ff ? w_count : DEPTH_W'(1);
               end else begin
                  wbi_in = wbi_next;
               end
            end
         end else begin
            pend_rd_in = r_go;
            if (rbi_ff == '0) begin
               rpos_in = r_start;
            end
            if (!r_go) begin
               pend_status_in = STATUS_NO_TOKENS;
            end else begin
               pend_status_in = STATUS_OK;
               mem_re         = 1'b1;
               rpos_in        = r_adv;
               if (r_last) begin
                  rbi_in       = '0;
                  pend_last_in = 1'b1;
                  if (cfg_ring_ff) begin
                     head_in  = r_adv;
                     count_in = r_count;
                  end else begin
                     count_in = '0;
                  end
               end else begin
                  rbi_in = rbi_next;
               end
            end
         end
         pend_occ_in = count_in;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEPTH: begin
               cfg_depth_in = csr_wdata;
               count_in     = reload_count;
               head_in      = '0;
            end
            CSR_PRODUCE: cfg_prate_in = csr_wdata;
            CSR_CONSUME: cfg_crate_in = csr_wdata;
            CSR_DELAY: begin
               cfg_delay_in = csr_wdata;
               count_in     = reload_count;
               head_in      = '0;
            end
            CSR_RING: cfg_ring_in = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (cmd.resp_load) begin
         rsp_status_in = pend_status_ff;
         rsp_last_in   = pend_last_ff;
         rsp_occ_in    = pend_occ_ff;
         rsp_token_in  = (pend_rd_ff && rd_valid_ff) ? rd_data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_depth_ff <= CSR_DATA_W'(MAX_DEPTH);
         cfg_prate_ff <= RATE_W'(1);
         cfg_crate_ff <= RATE_W'(1);
         cfg_delay_ff <= '0;
         cfg_ring_ff  <= 1'b1;
         count_ff     <= '0;
         head_ff      <= '0;
         wpos_ff      <= '0;
         wbi_ff       <= '0;
         rpos_ff      <= '0;
         rbi_ff       <= '0;
         valid_ff     <= '0;
      end else begin
         cfg_depth_ff <= cfg_depth_in;
         cfg_prate_ff <= cfg_prate_in;
         cfg_crate_ff <= cfg_crate_in;
         cfg_delay_ff <= cfg_delay_in;
         cfg_ring_ff  <= cfg_ring_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         wpos_ff      <= wpos_in;
         wbi_ff       <= wbi_in;
         rpos_ff      <= rpos_in;
         rbi_ff       <= rbi_in;
         if (mem_we) begin
            valid_ff[w_start] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      tok_ff         <= tok_in;
      norm_sel_ff    <= norm_sel_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      pend_occ_ff    <= pend_occ_in;
      pend_rd_ff     <= pend_rd_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_token_ff   <= rsp_token_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         token_mem[w_start] <= tok_ff;
      end
      if (mem_re) begin
         rd_data_ff  <= token_mem[r_start];
         rd_valid_ff <= valid_ff[r_start];
      end
   end

   sdfc_remdiv u_remdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (depth),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign sts.norm_needed = head_big || wpos_big || rpos_big;
   assign sts.div_done    = div_done;

   assign rsp_status     = rsp_status_ff;
   assign rsp_token_out  = rsp_token_ff;
   assign rsp_burst_last = rsp_last_ff;
   assign rsp_occupancy  = rsp_occ_ff;

endmodule

/* rtl/sdfc_ctrl.sv */
// ----------------------------------------------------------------------------
// SDF channel controller
// Sequences one request at a time through pointer normalization, execution
// and the result register handshake.
// ----------------------------------------------------------------------------
module sdfc_ctrl
   import sdfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_NORM = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_NORM;
            end
         end
         ST_NORM: begin
            if (sts.norm_needed) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.exec = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.div_commit = 1'b1;
               state_in       = ST_NORM;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.resp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/sdf_channel_rate_fifo.sv */
// ----------------------------------------------------------------------------
// SDF channel rate FIFO
// Token channel between a producer and a consumer actor with burst rates.
// ----------------------------------------------------------------------------
// Each request on the req_ channel is one token write or one token read. The
// first token of a burst checks the whole firing: room for produce_rate tokens
// on a write, at least consume_rate tokens on a read, or the empty and full
// flag in single-slot mode. A refused request returns a wait status.
// Every request returns exactly one result on the rsp_ channel, in order.
// A request passes the normalize, execute and result-load states in order; the next
// request is accepted only after its result has been loaded.
// When a depth change has left a slot pointer beyond the depth, each such
// pointer is reduced in turn by an eight-step remainder unit before execution.
// The result register lets the next request be accepted while the result is
// stalled; the block waits only when a new result finds it still occupied.
// The user must write registers through the csr_ port only while the channel is idle; the block does not enforce it.
// Writing the depth or delay reloads the occupancy and clears the head.
// Reset restores the register defaults and reads every slot as zero.
// ----------------------------------------------------------------------------
module sdf_channel_rate_fifo
   import sdfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [TOKEN_W-1:0]    req_token_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [TOKEN_W-1:0]    rsp_token_out,
   output logic                  rsp_burst_last,
   output logic [DEPTH_W-1:0]    rsp_occupancy,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   sdfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sdfc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_token_in   (req_token_in),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_status     (rsp_status),
      .rsp_token_out  (rsp_token_out),
      .rsp_burst_last (rsp_burst_last),
      .rsp_occupancy  (rsp_occupancy)
   );

endmodule
